### hdl/cbmj_pkg.sv
// Shared types, codes and constants of the copy-on-write block map with undo journal.
package cbmj_pkg;

  localparam int BLK_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_BITS  = 64;
  localparam int ROW_SHIFT = 6;

  localparam int MAX_BLOCKS_DEF    = 4096;
  localparam int JOURNAL_DEPTH_DEF = 64;

  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 13'd4096;
  localparam logic             BASE_PRESENT_RST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PRESENT  = 1'b1;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_COMMIT   = 2'd2,
    OP_ROLLBACK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_DELTA = 2'd0,
    SRC_BASE  = 2'd1,
    SRC_ZEROS = 2'd2,
    SRC_NONE  = 2'd3
  } source_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_pass;
    logic map_lookup;
    logic item_do;
    logic sweep_rd;
    logic commit_do;
    logic rb_empty;
    logic jrn_start;
    logic jrn_emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic row_last;
    logic fill_zero;
    logic jrn_last;
  } sts_t;

endpackage

### hdl/cbmj_ctrl.sv
// Controller state machine that sequences lookups, map sweeps and journal replay.
module cbmj_ctrl import cbmj_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_ITEM,
    S_SWEEP,
    S_FINISH,
    S_JOUT
  } state_e;

  state_e state_q;
  logic   stall_q;
  op_e    op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      stall_q <= 1'b1;
      op_q    <= OP_READ;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.row_last) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_op_i;
            stall_q <= 1'b1;
            if (in_op_i == OP_READ || in_op_i == OP_WRITE) begin
              state_q <= S_LOOKUP;
            end else begin
              state_q <= S_SWEEP;
            end
          end
        end
        S_LOOKUP: begin
          state_q <= S_ITEM;
        end
        S_ITEM: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        S_SWEEP: begin
          if (sts_i.row_last) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (op_q == OP_COMMIT || sts_i.fill_zero) begin
            if (sts_i.out_free) begin
              state_q <= S_IDLE;
              stall_q <= 1'b0;
            end
          end else begin
            state_q <= S_JOUT;
          end
        end
        S_JOUT: begin
          if (sts_i.out_free && sts_i.jrn_last) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.clr_pass   = (state_q == S_CLEAR);
    cmd_o.map_lookup = (state_q == S_LOOKUP);
    cmd_o.item_do    = (state_q == S_ITEM) && sts_i.out_free;
    cmd_o.sweep_rd   = (state_q == S_SWEEP);
    cmd_o.commit_do  = (state_q == S_FINISH) && (op_q == OP_COMMIT) && sts_i.out_free;
    cmd_o.rb_empty   = (state_q == S_FINISH) && (op_q == OP_ROLLBACK) && sts_i.fill_zero
                       && sts_i.out_free;
    cmd_o.jrn_start  = (state_q == S_FINISH) && (op_q == OP_ROLLBACK) && !sts_i.fill_zero;
    cmd_o.jrn_emit   = (state_q == S_JOUT) && sts_i.out_free;
  end

  assign in_stall_o = stall_q;

endmodule

### hdl/cbmj_dp.sv
// Datapath: block map memory, journal memory, fill and dirty state, result register.
module cbmj_dp import cbmj_pkg::*; #(
  parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [1:0]           opcode_i,
  input  logic [BLK_W-1:0]     block_num_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic [1:0]           source_o,
  output logic                 capture_preimage_o,
  output logic [BLK_W-1:0]     restore_block_o,
  output logic                 restore_valid_o,
  output logic                 flush_needed_o,
  output logic                 last_o
);

  localparam int MapBlocks = (MAX_BLOCKS > (1 << BLK_W)) ? (1 << BLK_W) : MAX_BLOCKS;
  localparam int MapRows   = (MapBlocks + ROW_BITS - 1) / ROW_BITS;
  localparam int RowAw     = (MapRows > 1) ? $clog2(MapRows) : 1;
  localparam int RowW      = 3 * ROW_BITS;
  localparam int JaW       = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int FillW     = $clog2(JOURNAL_DEPTH + 1);
  localparam logic [CFG_W-1:0]  LimCap  = CFG_W'(MapBlocks);
  localparam logic [RowAw-1:0]  RowLast = RowAw'(MapRows - 1);
  localparam logic [FillW-1:0]  FillMax = FillW'(JOURNAL_DEPTH);

  // Each map row holds the current bits, the committed bits and the journaled bits
  // of ROW_BITS consecutive blocks.
  logic [RowW-1:0]  map_mem_q [MapRows];
  logic [RowW-1:0]  map_rdata_q;
  logic [BLK_W-1:0] jrn_mem_q [JOURNAL_DEPTH];
  logic [BLK_W-1:0] jrn_rdata_q;

  logic [CFG_W-1:0] blocks_in_use_q;
  logic             base_present_q;

  op_e              op_q;
  logic [BLK_W-1:0] blk_q;

  logic [RowAw-1:0] row_cnt_q, row_cnt_d;
  logic             pend_q;
  logic [RowAw-1:0] pend_addr_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] jidx_q, jidx_d;
  logic [FillW-1:0] jidx_nxt;
  logic             dirty_q, dirty_d;

  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  source_e          source_q, source_d;
  logic             cap_q, cap_d;
  logic [BLK_W-1:0] rblk_q, rblk_d;
  logic             rval_q, rval_d;
  logic             flush_q, flush_d;
  logic             last_q, last_d;

  logic [CFG_W-1:0]    lim;
  logic                in_range;
  logic [RowAw-1:0]    item_row;
  logic [ROW_SHIFT-1:0] bit_idx;
  logic                cur_b, com_b, jr_b;
  logic                cap;
  logic                jfull;
  logic                item_wr;
  logic                flush;
  logic [RowW-1:0]     row_mod;
  logic [RowW-1:0]     row_sweep;
  logic                map_rd_en;
  logic [RowAw-1:0]    map_rd_addr;
  logic                map_we;
  logic [RowAw-1:0]    map_wa;
  logic [RowW-1:0]     map_wd;
  logic                jrn_rd_en;
  logic [JaW-1:0]      jrn_rd_addr;
  logic                jrn_we;

  // Blocks at or above the map size can never be in range, so the limit is capped there.
  assign lim      = (blocks_in_use_q > LimCap) ? LimCap : blocks_in_use_q;
  assign in_range = {1'b0, blk_q} < lim;
  assign item_row = blk_q[ROW_SHIFT +: RowAw];
  assign bit_idx  = blk_q[ROW_SHIFT-1:0];

  assign cur_b = map_rdata_q[bit_idx];
  assign com_b = map_rdata_q[ROW_BITS + bit_idx];
  assign jr_b  = map_rdata_q[2*ROW_BITS + bit_idx];
  assign cap   = com_b && !jr_b;
  assign jfull = (fill_q == FillMax);
  assign flush = dirty_q || (fill_q != '0);

  assign item_wr = cmd_i.item_do && (op_q == OP_WRITE) && in_range && !(cap && jfull);
  assign jrn_we  = item_wr && cap;

  always_comb begin
    row_mod                        = map_rdata_q;
    row_mod[bit_idx]               = 1'b1;
    row_mod[2*ROW_BITS + bit_idx]  = jr_b || cap;
  end

  // Commit makes the committed bits equal the current bits; rollback does the reverse.
  // Both empty the journal, so the journaled bits go to zero.
  always_comb begin
    if (op_q == OP_COMMIT) begin
      row_sweep = {{ROW_BITS{1'b0}}, map_rdata_q[ROW_BITS-1:0], map_rdata_q[ROW_BITS-1:0]};
    end else begin
      row_sweep = {{ROW_BITS{1'b0}}, map_rdata_q[2*ROW_BITS-1:ROW_BITS],
                   map_rdata_q[2*ROW_BITS-1:ROW_BITS]};
    end
  end

  assign map_rd_en   = cmd_i.map_lookup || cmd_i.sweep_rd;
  assign map_rd_addr = cmd_i.sweep_rd ? row_cnt_q : item_row;

  always_comb begin
    map_we = 1'b0;
    map_wa = item_row;
    map_wd = row_mod;
    if (cmd_i.clr_pass) begin
      map_we = 1'b1;
      map_wa = row_cnt_q;
      map_wd = '0;
    end else if (pend_q) begin
      map_we = 1'b1;
      map_wa = pend_addr_q;
      map_wd = row_sweep;
    end else if (item_wr) begin
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_rd_en) begin
      map_rdata_q <= map_mem_q[map_rd_addr];
    end
    if (map_we) begin
      map_mem_q[map_wa] <= map_wd;
    end
  end

  assign jidx_nxt    = FillW'(jidx_q + 1'b1);
  assign jrn_rd_en   = cmd_i.jrn_start || cmd_i.jrn_emit;
  assign jrn_rd_addr = cmd_i.jrn_start ? '0 : jidx_nxt[JaW-1:0];

  always_ff @(posedge clk_i) begin
    if (jrn_rd_en) begin
      jrn_rdata_q <= jrn_mem_q[jrn_rd_addr];
    end
    if (jrn_we) begin
      jrn_mem_q[fill_q[JaW-1:0]] <= blk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= BLOCKS_IN_USE_RST;
      base_present_q  <= BASE_PRESENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata_i;
        CFG_BASE_PRESENT:  base_present_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(opcode_i);
      blk_q <= block_num_i;
    end
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    if (cmd_i.clr_pass || cmd_i.sweep_rd) begin
      row_cnt_d = (row_cnt_q == RowLast) ? '0 : row_cnt_q + 1'b1;
    end

    fill_d  = fill_q;
    dirty_d = dirty_q;
    jidx_d  = jidx_q;
    if (item_wr) begin
      dirty_d = 1'b1;
      if (cap) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (cmd_i.commit_do && flush) begin
      dirty_d = 1'b0;
      fill_d  = '0;
    end
    if (cmd_i.jrn_start) begin
      jidx_d = '0;
    end
    if (cmd_i.jrn_emit) begin
      jidx_d = jidx_nxt;
      if (sts_o.jrn_last) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      fill_q      <= '0;
      jidx_q      <= '0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_cnt_q   <= row_cnt_d;
      pend_q      <= cmd_i.sweep_rd;
      pend_addr_q <= row_cnt_q;
      fill_q      <= fill_d;
      jidx_q      <= jidx_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register: a beat is loaded only when the slot is empty or being taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    source_d    = source_q;
    cap_d       = cap_q;
    rblk_d      = rblk_q;
    rval_d      = rval_q;
    flush_d     = flush_q;
    last_d      = last_q;
    if (cmd_i.item_do || cmd_i.commit_do || cmd_i.rb_empty || cmd_i.jrn_emit) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      source_d    = SRC_NONE;
      cap_d       = 1'b0;
      rblk_d      = '0;
      rval_d      = 1'b0;
      flush_d     = 1'b0;
      last_d      = 1'b1;
      if (cmd_i.item_do) begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (op_q == OP_READ) begin
          if (cur_b) begin
            source_d = SRC_DELTA;
          end else if (base_present_q) begin
            source_d = SRC_BASE;
          end else begin
            source_d = SRC_ZEROS;
          end
        end else if (cap && jfull) begin
          status_d = ST_FULL;
        end else begin
          cap_d = cap;
        end
      end
      if (cmd_i.commit_do) begin
        flush_d = flush;
      end
      if (cmd_i.jrn_emit) begin
        rblk_d = jrn_rdata_q;
        rval_d = 1'b1;
        last_d = sts_o.jrn_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    source_q <= source_d;
    cap_q    <= cap_d;
    rblk_q   <= rblk_d;
    rval_q   <= rval_d;
    flush_q  <= flush_d;
    last_q   <= last_d;
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.row_last  = (row_cnt_q == RowLast);
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.jrn_last  = (jidx_nxt == fill_q);

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign source_o           = source_q;
  assign capture_preimage_o = cap_q;
  assign restore_block_o    = rblk_q;
  assign restore_valid_o    = rval_q;
  assign flush_needed_o     = flush_q;
  assign last_o             = last_q;

endmodule

### hdl/cow_block_map_journal.sv
// Read and write: map lookup, then a result beat when the output is free; next item after.
// Commit: one map row per cycle over ceil(min(MAX_BLOCKS, 4096)/64) rows (64 by default).
// Rollback: same row sweep, then one journal beat per cycle while the output is not stalled.
// Results follow the sweep; the journal adds to rollback time, and a stalled output to both.
// After reset the map is cleared one row per cycle with input stalled;
// configuration writes are taken throughout.
module cow_block_map_journal import cbmj_pkg::*; #(
  parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [BLK_W-1:0]     block_num_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [1:0]           source_o,
  output logic                 capture_preimage_o,
  output logic [BLK_W-1:0]     restore_block_o,
  output logic                 restore_valid_o,
  output logic                 flush_needed_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;

  cbmj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (op_e'(opcode_i)),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  cbmj_dp #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .JOURNAL_DEPTH (JOURNAL_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .block_num_i        (block_num_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .source_o           (source_o),
    .capture_preimage_o (capture_preimage_o),
    .restore_block_o    (restore_block_o),
    .restore_valid_o    (restore_valid_o),
    .flush_needed_o     (flush_needed_o),
    .last_o             (last_o)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while one is in flight");

  a_load_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.item_do, cmd.commit_do, cmd.rb_empty, cmd.jrn_emit}))
    else $error("more than one result source loads the output register");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.item_do || cmd.commit_do || cmd.rb_empty || cmd.jrn_emit)
      |-> !(out_valid_o && out_stall_i))
    else $error("result beat overwritten while stalled");

  a_cap_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capture_preimage_o |-> status_o == ST_OK && source_o == SRC_NONE)
    else $error("preimage capture on a failed or non-write beat");

endmodule
